/* rtl/core/websocket_frame_receiver_assert.svh */
// Assertion macros shared by the receiver modules.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

`define WSFR_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define WSFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define WSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/wsfr_pkg.sv */
package wsfr_pkg;

   localparam int BufferBytes = 128;
   localparam int MaxFrameLen = BufferBytes - 6;

   localparam logic [1:0] KindPayload     = 2'd0;
   localparam logic [1:0] KindEmpty       = 2'd1;
   localparam logic [1:0] KindBadHeader   = 2'd2;
   localparam logic [1:0] KindBadOpcode   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic       last;
      logic [6:0] frame_length;
   } rsp_type;

endpackage

/* rtl/core/wsfr_decode.sv */
`include "websocket_frame_receiver_assert.svh"

module wsfr_decode
   import wsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       res_valid,
   output rsp_type    res
);

   localparam logic [1:0] PhHeader    = 2'd0;
   localparam logic [1:0] PhHeaderBad = 2'd1;
   localparam logic [1:0] PhPayload   = 2'd2;
   localparam logic [1:0] PhDiscard   = 2'd3;

   localparam logic [2:0] HeaderLast   = 3'd5;
   localparam logic [7:0] MaxLen       = 8'(MaxFrameLen);
   localparam logic [3:0] FinNibble    = 4'h8;
   localparam logic [3:0] OpcodeBinary = 4'h2;

   logic [1:0]  phase_ff, phase_in, phase_hdr;
   logic [7:0]  first_header_ff, first_header_in;
   logic [6:0]  length_left_ff, length_left_in;
   logic [6:0]  frame_len_ff, frame_len_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [7:0]  key_byte;

   always_comb begin
      unique case (mask_pos_ff)
         2'd0: key_byte = mask_key_ff[31:24];
         2'd1: key_byte = mask_key_ff[23:16];
         2'd2: key_byte = mask_key_ff[15:8];
         2'd3: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      phase_hdr       = phase_ff;
      first_header_in = first_header_ff;
      length_left_in  = length_left_ff;
      frame_len_in    = frame_len_ff;
      mask_key_in     = mask_key_ff;
      mask_pos_in     = mask_pos_ff;
      header_count_in = header_count_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (in_valid) begin
         unique case (phase_ff)
            PhDiscard: begin
               phase_in = PhDiscard;
            end
            PhPayload: begin
               res_valid        = 1'b1;
               res.kind         = KindPayload;
               res.payload      = in_byte ^ key_byte;
               res.last         = (length_left_ff == 7'd1);
               res.frame_length = frame_len_ff;
               mask_pos_in      = mask_pos_ff + 2'd1;
               length_left_in   = length_left_ff - 7'd1;
               if (length_left_ff == 7'd1) begin
                  phase_in        = PhHeader;
                  header_count_in = '0;
               end
            end
            PhHeader, PhHeaderBad: begin
               if (header_count_ff == 3'd0) begin
                  first_header_in = in_byte;
                  phase_hdr       = PhHeader;
               end else if (header_count_ff == 3'd1) begin
                  frame_len_in = in_byte[6:0];
                  if (!in_byte[7] || ({1'b0, in_byte[6:0]} > MaxLen)) begin
                     phase_hdr = PhHeaderBad;
                  end
               end else begin
                  mask_key_in = {mask_key_ff[23:0], in_byte};
               end
               phase_in        = phase_hdr;
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff == HeaderLast) begin
                  header_count_in  = '0;
                  mask_pos_in      = '0;
                  res.last         = 1'b1;
                  res.frame_length = frame_len_ff;
                  priority if (phase_hdr == PhHeaderBad
                               || first_header_ff[7:4] != FinNibble) begin
                     res_valid = 1'b1;
                     res.kind  = KindBadHeader;
                     phase_in  = PhDiscard;
                  end else if (first_header_ff[3:0] != OpcodeBinary) begin
                     res_valid = 1'b1;
                     res.kind  = KindBadOpcode;
                     phase_in  = PhDiscard;
                  end else if (frame_len_ff == 7'd0) begin
                     res_valid = 1'b1;
                     res.kind  = KindEmpty;
                     phase_in  = PhHeader;
                  end else begin
                     res.last       = 1'b0;
                     length_left_in = frame_len_ff;
                     phase_in       = PhPayload;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhHeader;
         first_header_ff <= '0;
         length_left_ff  <= '0;
         frame_len_ff    <= '0;
         mask_key_ff     <= '0;
         mask_pos_ff     <= '0;
         header_count_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         first_header_ff <= first_header_in;
         length_left_ff  <= length_left_in;
         frame_len_ff    <= frame_len_in;
         mask_key_ff     <= mask_key_in;
         mask_pos_ff     <= mask_pos_in;
         header_count_ff <= header_count_in;
      end
   end

   `WSFR_ASSERT_ALWAYS(a_header_count_range, header_count_ff <= HeaderLast, "header count overran")
   `WSFR_ASSERT_NEXT(a_discard_sticks, phase_ff == PhDiscard, phase_ff == PhDiscard, "left discard")
   `WSFR_ASSERT_IMPLY(a_marker_shape, res_valid && res.kind != KindPayload,
                      res.payload == 8'd0 && res.last, "marker carries data")
   `WSFR_ASSERT_IMPLY(a_payload_has_length, phase_ff == PhPayload,
                      length_left_ff != 7'd0, "payload phase with nothing left")

endmodule

/* rtl/core/wsfr_out_buf.sv */
`include "websocket_frame_receiver_assert.svh"

module wsfr_out_buf
   import wsfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    rsp_free;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = rsp_valid_ff;
   assign out_data   = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || out_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push_valid;
            rsp_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `WSFR_ASSERT_ALWAYS(a_skid_behind_rsp, !skid_valid_ff || rsp_valid_ff, "skid filled ahead")
   `WSFR_ASSERT_NEXT(a_skid_drains, skid_valid_ff && out_ready,
                     !skid_valid_ff && rsp_valid_ff, "skid did not drain")

endmodule

/* rtl/core/websocket_frame_receiver.sv */
// Each result is registered in the output register, or in the skid register while that one stalls.
// One request per cycle while req_tready is high; only the last header byte gives a result.
// A two-entry output stage keeps req_tready high unless two results wait downstream.
// Reset is synchronous and active high; it returns the decoder to the first header byte
// and clears the error state, so discarding after a bad header or opcode ends only on reset.
module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [7:0] payload, [14:8] frame_length, [15] zero
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast
);

   logic    accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign accept = req_tvalid && req_tready;

   wsfr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_data.frame_length, out_data.payload};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule

/* tb/tb_top.sv */
module tb_top;
   import wsfr_pkg::*;

   localparam int ByteTarget    = 420;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 8;
   localparam int HeaderBytes   = 6;
   localparam logic [3:0] FinOnly      = 4'h8;
   localparam logic [3:0] OpcodeBinary = 4'h2;

   typedef enum logic [1:0] {
      AwaitHeader, HeaderFaulty, InPayload, Discarding
   } decode_phase_type;
   typedef enum int {
      FaultFlags, FaultNoMask, FaultTooLong, FaultOpcode, FaultBoth
   } closing_fault_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   decode_phase_type phase_now    = AwaitHeader;
   logic [7:0]       first_byte   = '0;
   logic [6:0]       bytes_left   = '0;
   logic [6:0]       length_field = '0;
   logic [31:0]      key_word     = '0;
   logic [1:0]       key_index    = '0;
   logic [2:0]       header_bytes = '0;

   rsp_type decoded_queue[$];
   int      bytes_sent      = 0;
   int      frames_sent     = 0;
   int      results_checked = 0;
   int      failures        = 0;
   bit      quiet_tx        = 1'b0;
   bit      quiet_rx        = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{8'h82, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b1, '{KindEmpty, 8'h00, 1'b1, 7'd0}},
      '{8'h82, 1'b0, '0},
      '{8'h81, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hff, 1'b1, '{KindPayload, 8'hff, 1'b1, 7'd1}},
      '{8'h82, 1'b0, '0},
      '{8'h85, 1'b0, '0},
      '{8'ha5, 1'b0, '0},
      '{8'h3c, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'h5a, 1'b0, '0},
      '{8'hc3, 1'b0, '0},
      '{8'h7e, 1'b0, '0}
   };

   always #4 clock = ~clock;

   websocket_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic void decode_byte(input logic [7:0] b, output bit produced,
                                       output rsp_type r);
      logic [7:0] key_byte;
      produced = 1'b0;
      r = '0;
      if (phase_now == Discarding) return;
      if (phase_now == InPayload) begin
         key_byte = key_word[8 * (3 - key_index) +: 8];
         key_index = key_index + 2'd1;
         bytes_left = bytes_left - 7'd1;
         r = '{KindPayload, b ^ key_byte, bytes_left == 7'd0, length_field};
         if (bytes_left == 7'd0) begin
            phase_now = AwaitHeader;
            header_bytes = '0;
         end
         produced = 1'b1;
         return;
      end
      case (header_bytes)
         3'd0: begin
            first_byte = b;
            phase_now = AwaitHeader;
         end
         3'd1: begin
            length_field = b[6:0];
            if (!b[7] || b[6:0] > MaxFrameLen) phase_now = HeaderFaulty;
         end
         default: key_word = {key_word[23:0], b};
      endcase
      header_bytes = header_bytes + 3'd1;
      if (header_bytes < HeaderBytes) return;
      header_bytes = '0;
      key_index = '0;
      produced = 1'b1;
      if (phase_now == HeaderFaulty || first_byte[7:4] != FinOnly) begin
         phase_now = Discarding;
         r = '{KindBadHeader, 8'h00, 1'b1, length_field};
      end else if (first_byte[3:0] != OpcodeBinary) begin
         phase_now = Discarding;
         r = '{KindBadOpcode, 8'h00, 1'b1, length_field};
      end else if (length_field == 7'd0) begin
         phase_now = AwaitHeader;
         r = '{KindEmpty, 8'h00, 1'b1, 7'd0};
      end else begin
         bytes_left = length_field;
         phase_now = InPayload;
         produced = 1'b0;
      end
   endfunction

   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // A request is taken at the rising edge where valid and ready are both high.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input rsp_type want = '0);
      int      gap;
      bit      produced;
      rsp_type r;
      gap = pick_gap(quiet_tx);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, produced, r);
      if (produced) decoded_queue.push_back(typed ? want : r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] head0, input logic [7:0] head1, input int body);
      send_byte(head0);
      send_byte(head1);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      repeat (body) send_byte(8'($urandom_range(0, 255)));
      frames_sent++;
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (decoded_queue.size() != 0);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0) quiet_rx = ~quiet_rx;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(quiet_rx);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[14:8]};
         if (decoded_queue.size() == 0) begin
            $error("unexpected result: kind %0d payload %02h last %0d frame_length %0d",
                   seen.kind, seen.payload, seen.last, seen.frame_length);
            failures++;
         end else begin
            want = decoded_queue.pop_front();
            results_checked++;
            if (seen.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, seen.kind);
               failures++;
            end
            if (seen.payload !== want.payload) begin
               $error("payload: expected %02h, got %02h", want.payload, seen.payload);
               failures++;
            end
            if (seen.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, seen.last);
               failures++;
            end
            if (seen.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, seen.frame_length);
               failures++;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                roll;
      int                len;
      int                tail;
      logic [3:0]        bad_nibble;
      logic [3:0]        bad_opcode;
      logic [7:0]        head0;
      logic [7:0]        head1;
      closing_fault_type fault;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].want);
      end
      hold_until_drained();

      while (bytes_sent < ByteTarget) begin
         quiet_tx = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (frames_sent == 8 || roll >= 97) len = MaxFrameLen;
         else if (roll < 10) len = 0;
         else if (roll < 88) len = $urandom_range(1, 12);
         else len = $urandom_range(13, 60);
         send_frame(8'h82, 8'h80 | 8'(len), len);
         if ($urandom_range(0, 19) == 0) hold_until_drained();
      end

      // Any fault locks the decoder until reset, so the run closes with a single one.
      do bad_nibble = 4'($urandom_range(0, 15)); while (bad_nibble == FinOnly);
      do bad_opcode = 4'($urandom_range(0, 15)); while (bad_opcode == OpcodeBinary);
      fault = closing_fault_type'($urandom_range(0, 4));
      head0 = {FinOnly, OpcodeBinary};
      head1 = {1'b1, 7'($urandom_range(0, MaxFrameLen))};
      case (fault)
         FaultFlags:   head0 = {bad_nibble, OpcodeBinary};
         FaultNoMask:  head1 = {1'b0, 7'($urandom_range(0, 127))};
         FaultTooLong: head1 = {1'b1, 7'($urandom_range(MaxFrameLen + 1, 127))};
         FaultOpcode:  head0 = {FinOnly, bad_opcode};
         default: begin
            head0 = {bad_nibble, bad_opcode};
            head1 = {1'b0, 7'($urandom_range(0, 127))};
         end
      endcase
      send_frame(head0, head1, 0);
      tail = $urandom_range(10, 20);
      repeat (tail) send_byte(8'($urandom_range(0, 255)));

      req_tvalid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d results from %0d request bytes: %s %0d random frames.",
               results_checked, bytes_sent, "directed frames and", frames_sent);
      $display("The stream ended with a %s fault, after which %0d further bytes were dropped.",
               fault.name(), tail);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
